[rtl/fpm_pkg.sv]
// shared types and constants for the single-precision multiplier
package fpm_pkg;

  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned SigW  = FracW + 1;
  localparam int unsigned ProdW = 2 * SigW;
  localparam logic [ExpW-1:0] ExpMax = 8'hFF;
  localparam logic [9:0] Bias = 10'd127;
  localparam logic [31:0] QNan = 32'h7FC00000;

  // special-case classification carried down the pipe
  typedef enum logic [1:0] {
    SPC_NONE,
    SPC_NAN,
    SPC_INF,
    SPC_ZERO
  } spc_e;

  // stage 1 -> stage 2: unpacked operands
  typedef struct packed {
    logic            sign;
    spc_e            spc;
    logic [9:0]      exp;   // signed biased exponent sum less bias
    logic [SigW-1:0] sig_a;
    logic [SigW-1:0] sig_b;
  } unp_t;

  // stage 2 -> stage 3: raw product
  typedef struct packed {
    logic             sign;
    spc_e             spc;
    logic [9:0]       exp;
    logic [ProdW-1:0] prod;
  } mul_t;

endpackage

[rtl/fp32_multiplier.sv]
// top level: three-stage pipelined single-precision multiplier
// an accepted item passes the unp_q, mul_q and product_q registers in turn to the output
// throughput: one item per cycle while out_stall_i is low, set by the 24x24 significand multiplier stage
// a stall freezes every full stage whose successor is full and held; bubbles are squeezed out
// reset: rst_ni asynchronous active low clears all stage valid bits
// special operands: nan/invalid give 0x7fc00000, subnormals flush to zero
module fp32_multiplier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] product_o
);
  import fpm_pkg::*;

  unp_t unp_d, unp_q;
  mul_t mul_q;
  logic [31:0] product_d, product_q;
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  // a stage advances when its successor is empty or moving
  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  // stage 1: decode
  fpm_unpack u_unpack (
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .unp_o       (unp_d)
  );

  // stage 3 logic: normalize and round the registered product
  fpm_round u_round (
    .mul_i     (mul_q),
    .product_o (product_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) unp_q <= unp_d;
    // stage 2: significand multiply
    if (en2) begin
      mul_q.sign <= unp_q.sign;
      mul_q.spc  <= unp_q.spc;
      mul_q.exp  <= unp_q.exp;
      mul_q.prod <= unp_q.sig_a * unp_q.sig_b;
    end
    if (en3) product_q <= product_d;
  end

  assign out_valid_o = v3_q;
  assign product_o   = product_q;

`ifndef SYNTHESIS
  // a stalled result must stay put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(product_o))
    else $error("result changed under stall");
  // input is never refused while the first stage is empty
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> !in_stall_o)
    else $error("stall with empty first stage");
  // an accepted item shows up in the stage-one register next cycle
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v1_q)
    else $error("accepted item lost");
`endif

endmodule

[rtl/fpm_unpack.sv]
// operand decode and special-case classification
module fpm_unpack (
  input  logic [31:0]  operand_a_i,
  input  logic [31:0]  operand_b_i,
  output fpm_pkg::unp_t unp_o
);
  import fpm_pkg::*;

  logic [ExpW-1:0] ea, eb;
  logic [FracW-1:0] fa, fb;
  logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;

  always_comb begin
    ea = operand_a_i[30:23];
    eb = operand_b_i[30:23];
    fa = operand_a_i[22:0];
    fb = operand_b_i[22:0];
    nan_a  = (ea == ExpMax) && (fa != '0);
    nan_b  = (eb == ExpMax) && (fb != '0);
    inf_a  = (ea == ExpMax) && (fa == '0);
    inf_b  = (eb == ExpMax) && (fb == '0);
    zero_a = (ea == '0);
    zero_b = (eb == '0);
    unp_o.sign  = operand_a_i[31] ^ operand_b_i[31];
    unp_o.exp   = {2'b00, ea} + {2'b00, eb} - Bias;
    unp_o.sig_a = {1'b1, fa};
    unp_o.sig_b = {1'b1, fb};
    if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
      unp_o.spc = SPC_NAN;
    end else if (inf_a || inf_b) begin
      unp_o.spc = SPC_INF;
    end else if (zero_a || zero_b) begin
      unp_o.spc = SPC_ZERO;
    end else begin
      unp_o.spc = SPC_NONE;
    end
  end

endmodule

[rtl/fpm_round.sv]
// normalize, round to nearest even and pack the result
module fpm_round (
  input  fpm_pkg::mul_t mul_i,
  output logic [31:0]   product_o
);
  import fpm_pkg::*;

  logic          hi;
  logic [SigW:0] mant;
  logic [SigW-1:0] trunc;
  logic          g, st;
  logic [9:0]    e;

  always_comb begin
    hi = mul_i.prod[ProdW-1];
    if (hi) begin
      trunc = mul_i.prod[47:24];
      g     = mul_i.prod[23];
      st    = |mul_i.prod[22:0];
    end else begin
      trunc = mul_i.prod[46:23];
      g     = mul_i.prod[22];
      st    = |mul_i.prod[21:0];
    end
    mant = {1'b0, trunc} + {{SigW{1'b0}}, (g && (st || trunc[0]))};
    e = mul_i.exp + {9'd0, hi};
    if (mant[SigW]) begin
      mant = mant >> 1;
      e    = e + 10'd1;
    end
    case (mul_i.spc)
      SPC_NAN:  product_o = QNan;
      SPC_INF:  product_o = {mul_i.sign, ExpMax, {FracW{1'b0}}};
      SPC_ZERO: product_o = {mul_i.sign, 31'd0};
      default: begin
        if (!e[9] && (e >= 10'd255)) begin
          product_o = {mul_i.sign, ExpMax, {FracW{1'b0}}};
        end else if (e[9] || (e == 10'd0)) begin
          product_o = {mul_i.sign, 31'd0};
        end else begin
          product_o = {mul_i.sign, e[7:0], mant[FracW-1:0]};
        end
      end
    endcase
  end

endmodule

[sim/testbench.sv]
// self-checking testbench for the pipelined single-precision multiplier
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned IdleLimit = 2000;
  localparam logic [31:0] InfBits   = 32'h7F800000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] operand_a_i;
  logic [31:0] operand_b_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] product_o;

  fp32_multiplier uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .product_o  (product_o)
  );

  // operand pairs waiting to be sent, and products still owed by the block
  logic [63:0] pending_pairs[$];
  logic [31:0] owed_products[$];

  int unsigned idle_pct_in;   // chance per cycle that the sender holds off
  int unsigned stall_pct_out; // chance per cycle that the receiver stalls
  int unsigned error_count = 0;
  int unsigned products_checked = 0;
  int unsigned quiet_cycles;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // expected product: round to nearest even, subnormals flushed, canonical nan
  function automatic logic [31:0] fmul_expect(logic [31:0] a, logic [31:0] b);
    logic        sgn;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic [47:0] prod, rem, half;
    logic [24:0] mant;
    int          ex;
    int unsigned sh;
    sgn = a[31] ^ b[31];
    ea = a[30:23];
    eb = b[30:23];
    fa = a[22:0];
    fb = b[22:0];
    if ((ea == 8'hFF && fa != 0) || (eb == 8'hFF && fb != 0)) return fpm_pkg::QNan;
    if ((ea == 8'hFF && eb == 0) || (eb == 8'hFF && ea == 0)) return fpm_pkg::QNan;
    if (ea == 8'hFF || eb == 8'hFF) return {sgn, 31'b0} | InfBits;
    if (ea == 0 || eb == 0) return {sgn, 31'b0};
    prod = {24'b0, 1'b1, fa} * {24'b0, 1'b1, fb};
    ex = int'(ea) + int'(eb) - 127;
    // significand product sits in [1,4): pick the normalizing shift
    if (prod[47]) begin
      sh = 24;
      ex++;
    end else begin
      sh = 23;
    end
    mant = 25'(prod >> sh);
    rem  = prod & ((48'd1 << sh) - 48'd1);
    half = 48'd1 << (sh - 1);
    if (rem > half || (rem == half && mant[0])) mant++;
    // rounding carried out to 2.0
    if (mant[24]) begin
      mant = mant >> 1;
      ex++;
    end
    if (ex >= 255) return {sgn, 31'b0} | InfBits;
    if (ex <= 0) return {sgn, 31'b0};
    return {sgn, 8'(ex), mant[22:0]};
  endfunction

  task automatic report_mismatch(input logic [31:0] got, input logic [31:0] want);
    $display("mismatch: product %h, expected %h", got, want);
    error_count++;
  endtask

  // random operand biased toward interesting exponents and fractions
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'hFF;
      1: v[30:23] = 8'h00;
      2: v[30:23] = 8'($urandom_range(0, 8));
      3: v[30:23] = 8'($urandom_range(247, 254));
      4: v[22:0] = 23'($urandom_range(0, 3)) << $urandom_range(0, 22);
      5: v[30:23] = 8'($urandom_range(100, 154));
      default: ;
    endcase
    return v;
  endfunction

  // driver: next pair goes out when the current one is taken or none is held
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      operand_a_i <= '0;
      operand_b_i <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_pairs.size() > 0 && $urandom_range(0, 99) >= idle_pct_in) begin
        logic [63:0] pair;
        pair = pending_pairs.pop_front();
        owed_products.push_back(fmul_expect(pair[63:32], pair[31:0]));
        in_valid_i  <= 1'b1;
        operand_a_i <= pair[63:32];
        operand_b_i <= pair[31:0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: check accepted products, randomize stall, watch for hangs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (owed_products.size() == 0) begin
          $display("unexpected product %h", product_o);
          error_count++;
        end else begin
          logic [31:0] want;
          want = owed_products.pop_front();
          if (product_o !== want) report_mismatch(product_o, want);
          products_checked++;
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct_out);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit && (pending_pairs.size() > 0 || owed_products.size() > 0)) begin
        $display("timeout: no progress for %0d cycles", IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic run_phase(input int unsigned idle_p, input int unsigned stall_p,
                           input int unsigned count);
    idle_pct_in   = idle_p;
    stall_pct_out = stall_p;
    repeat (count) pending_pairs.push_back({pick_operand(), pick_operand()});
    wait (pending_pairs.size() == 0 && owed_products.size() == 0);
    @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] corner[$];
    rst_ni = 1'b0;
    idle_pct_in = 0;
    stall_pct_out = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zeros, subnormals, infinities, nans, extremes, ties, overflow, underflow
    corner = '{32'h00000000, 32'h80000000, 32'h00000001, 32'h7F800000, 32'hFF800000,
               32'h7FC00000, 32'hFF800001, 32'h3F800000, 32'h7F7FFFFF, 32'h00800000,
               32'hFFFFFFFF, 32'hBFC00001};
    foreach (corner[i]) pending_pairs.push_back({corner[i], corner[(i * 5 + 3) % 12]});
    pending_pairs.push_back({32'h3F800001, 32'h3F7FFFFF}); // rounding tie region
    pending_pairs.push_back({32'h3FFFFFFF, 32'h3FFFFFFF}); // rounds down to just below 4.0, no carry
    pending_pairs.push_back({32'h7F000000, 32'h40000000}); // overflow to infinity
    pending_pairs.push_back({32'h00800000, 32'h3F7FFFFF}); // underflow flush
    pending_pairs.push_back({32'h00800000, 32'h3F800001}); // stays normal
    pending_pairs.push_back({32'h1F800000, 32'h20000000}); // just below the smallest normal, flushed
    pending_pairs.push_back({32'h3FC00000, 32'h3F800001}); // tie, odd keeps up
    pending_pairs.push_back({32'hFF7FFFFF, 32'h3F800000}); // negative max
    wait (pending_pairs.size() == 0 && owed_products.size() == 0);

    run_phase(0, 0, 500);
    run_phase(68, 0, 450);
    run_phase(0, 68, 450);
    run_phase(7, 7, 500);
    repeat (20) @(posedge clk_i);

    $display("covered %0d products: specials, rounding ties, overflow and flush-to-zero",
             products_checked);
    $display("throttling phases: none, sender idle, receiver stall, both light");
    if (error_count == 0 && owed_products.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
